[hdl/fifo_queue_with_search_unit_defines.svh]
// Assertion macros used by the checker of the queue.
`ifndef FIFO_QUEUE_WITH_SEARCH_UNIT_DEFINES_SVH
`define FIFO_QUEUE_WITH_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define FQS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("queue check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define FQS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("queue check failed");

`endif

[hdl/fqs_pkg.sv]
`default_nettype none

package fqs_pkg;

   // Queue geometry
   localparam int DEPTH  = 16;
   localparam int WORD_W = 32;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Operation codes
   localparam logic [1:0] KIND_ENQ    = 2'd0;
   localparam logic [1:0] KIND_DEQ    = 2'd1;
   localparam logic [1:0] KIND_SEARCH = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic [1:0]               kind;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] value_out;
      logic [CNT_W-1:0]         position;
      logic [CNT_W-1:0]         occupancy;
      logic                     is_empty;
   } rsp_type;

   // Command broadcast to every cell
   typedef struct packed {
      logic     enq;
      logic     deq;
      word_type word;
   } cell_cmd_type;

endpackage

`default_nettype wire

[hdl/fqs_cell.sv]
`default_nettype none

module fqs_cell
   import fqs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_cmd_type cmd,
   input  wire logic         front_valid,
   input  wire logic         prior_in,
   input  wire logic         back_valid,
   input  wire word_type     back_data,
   output logic              valid,
   output word_type          data,
   output logic              prior_out,
   output logic              first_hit
);

   logic     valid_ff;
   word_type data_ff;
   logic     is_tail;
   logic     hit;

   // This cell is the next free slot when its front neighbor is occupied and it is empty
   assign is_tail = front_valid && !valid_ff;

   // Shift toward the front on dequeue, load at the tail on enqueue
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.deq) begin
         valid_ff <= back_valid;
      end else if (cmd.enq && is_tail) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.deq) begin
         data_ff <= back_data;
      end else if (cmd.enq && is_tail) begin
         data_ff <= cmd.word;
      end
   end

   // Compare against the target and pass the match flag backward
   assign hit       = valid_ff && (data_ff == cmd.word);
   assign first_hit = hit && !prior_in;
   assign prior_out = prior_in || hit;

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

`default_nettype wire

[hdl/fifo_queue_with_search_unit.sv]
// Channel | Ports                          | Direction | Payload
// request | req_valid, req_stall, req_data | in        | kind, value
// response| rsp_valid, rsp_stall, rsp_data | out       | status, value_out, position,
//         |                                |           | occupancy, is_empty
// The response is registered when the request is accepted, even as the last response leaves.
// The search compare ripples its match flag through the row of cells, which sets the path.
// Reset clears the cell valid bits, the occupancy counter and the response valid flag at once.
// A stalled response holds its register and stalls the request side in the same cycle.
`default_nettype none

module fifo_queue_with_search_unit
   import fqs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic             accept;
   logic             full;
   logic             empty;
   logic             enq_do;
   logic             deq_do;
   cell_cmd_type     cmd;
   logic             cell_valid [DEPTH];
   word_type         cell_data  [DEPTH];
   logic             cell_first [DEPTH];
   logic             prior      [DEPTH+1];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] pos;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   logic             rsp_valid_ff;

   // Hold off new requests while a response waits to transfer
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign full   = cell_valid[DEPTH-1];
   assign empty  = !cell_valid[0];
   assign enq_do = accept && (req_data.kind == KIND_ENQ) && !full;
   assign deq_do = accept && (req_data.kind == KIND_DEQ) && !empty;

   assign cmd.enq  = enq_do;
   assign cmd.deq  = deq_do;
   assign cmd.word = word_type'(req_data.value);

   // Row of cells, front at index zero
   assign prior[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic     front_v;
      logic     back_v;
      word_type back_d;

      if (i == 0) begin : g_front
         assign front_v = 1'b1;
      end else begin : g_mid
         assign front_v = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_back
         assign back_v = 1'b0;
         assign back_d = '0;
      end else begin : g_inner
         assign back_v = cell_valid[i+1];
         assign back_d = cell_data[i+1];
      end

      fqs_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .front_valid (front_v),
         .prior_in    (prior[i]),
         .back_valid  (back_v),
         .back_data   (back_d),
         .valid       (cell_valid[i]),
         .data        (cell_data[i]),
         .prior_out   (prior[i+1]),
         .first_hit   (cell_first[i])
      );
   end

   // Encode the single first match into a 1-based position
   always_comb begin
      pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_first[i]) begin
            pos = pos | CNT_W'(i + 1);
         end
      end
   end

   // Advance the occupancy counter
   always_comb begin
      count_in = count_ff;
      if (enq_do) begin
         count_in = count_ff + CNT_W'(1);
      end else if (deq_do) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Build the response for the accepted request
   always_comb begin
      rsp_in           = '0;
      rsp_in.occupancy = count_in;
      rsp_in.is_empty  = (count_in == '0);
      case (req_data.kind)
         KIND_ENQ: begin
            rsp_in.status = full ? ST_FULL : ST_OK;
         end
         KIND_DEQ: begin
            if (empty) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               rsp_in.value_out = cell_data[0];
            end
         end
         KIND_SEARCH: begin
            rsp_in.position = pos;
            rsp_in.status   = prior[DEPTH] ? ST_OK : ST_NOTFOUND;
         end
         default: begin
            rsp_in.status = ST_OK;
         end
      endcase
   end

   // Load the response register on accept, drop it once transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[hdl/fqs_checker.sv]
`default_nettype none
`include "fifo_queue_with_search_unit_defines.svh"

module fqs_checker
   import fqs_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   logic req_xfer;
   logic rsp_held;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_held = rsp_valid && rsp_stall;

   // A stalled response stays and holds its payload
   `FQS_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_data))

   // Every accepted request shows a response on the next cycle
   `FQS_ASSERT_NEXT(a_rsp_follows, req_xfer, rsp_valid)

   // No request transfers while a response is held back
   `FQS_ASSERT_NOW(a_no_overrun, rsp_held, req_stall)

   // A rejected enqueue reports a full queue
   `FQS_ASSERT_NOW(a_full_count, rsp_valid && (rsp_data.status == ST_FULL),
      (rsp_data.occupancy == CNT_W'(DEPTH)) && !rsp_data.is_empty)

endmodule

bind fifo_queue_with_search_unit fqs_checker u_fqs_checker (.*);

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import fqs_pkg::*;

   // Code 3 is unused by the block and acts as a no-op
   localparam logic [1:0] KIND_NOP = 2'd3;

   localparam word_type WORD_MIN = 32'h8000_0000;
   localparam word_type WORD_MAX = 32'h7fff_ffff;

   localparam int ITEMS_PER_BLOCK = 50;
   localparam int RANDOM_BLOCKS   = 23;
   localparam int TIMEOUT_NS      = 10_000_000;
   localparam int PLAN_ROWS       = 15;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Hand-written expectation that travels with the request payload
   logic    req_known = 1'b0;
   rsp_type req_known_rsp = '0;

   fifo_queue_with_search_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // Directed plan: repeated rows step the value by one per transfer
   typedef struct {
      logic [1:0] kind;
      word_type   value;
      int         reps;
      bit         has_rsp;
      logic [1:0] status;
      word_type   value_out;
      int         position;
      int         occupancy;
      bit         is_empty;
   } plan_row_type;

   plan_row_type plan [PLAN_ROWS] = '{
      '{KIND_DEQ,    32'h0,        1,  1'b1, ST_EMPTY,    32'h0,    0, 0,  1'b1},
      '{KIND_SEARCH, 32'h0,        1,  1'b1, ST_NOTFOUND, 32'h0,    0, 0,  1'b1},
      '{KIND_NOP,    32'hffff_ffff, 1, 1'b1, ST_OK,       32'h0,    0, 0,  1'b1},
      '{KIND_ENQ,    WORD_MIN,     1,  1'b1, ST_OK,       32'h0,    0, 1,  1'b0},
      '{KIND_ENQ,    WORD_MAX,     1,  1'b1, ST_OK,       32'h0,    0, 2,  1'b0},
      '{KIND_SEARCH, WORD_MAX,     1,  1'b1, ST_OK,       32'h0,    2, 2,  1'b0},
      '{KIND_SEARCH, WORD_MIN,     1,  1'b1, ST_OK,       32'h0,    1, 2,  1'b0},
      '{KIND_ENQ,    32'd100,      14, 1'b0, ST_OK,       32'h0,    0, 0,  1'b0},
      '{KIND_ENQ,    32'd5,        1,  1'b1, ST_FULL,     32'h0,    0, 16, 1'b0},
      '{KIND_SEARCH, 32'd113,      1,  1'b0, ST_OK,       32'h0,    0, 0,  1'b0},
      '{KIND_NOP,    32'h0,        1,  1'b1, ST_OK,       32'h0,    0, 16, 1'b0},
      '{KIND_DEQ,    32'h0,        1,  1'b1, ST_OK,       WORD_MIN, 0, 15, 1'b0},
      '{KIND_SEARCH, WORD_MIN,     1,  1'b1, ST_NOTFOUND, 32'h0,    0, 15, 1'b0},
      '{KIND_ENQ,    32'hffff_ffff, 1, 1'b0, ST_OK,       32'h0,    0, 0,  1'b0},
      '{KIND_SEARCH, 32'hffff_ffff, 1, 1'b1, ST_OK,       32'h0,    16, 16, 1'b0}
   };

   // Shadow copy of the ring
   word_type    cells [DEPTH];
   int unsigned head_idx = 0;
   int unsigned tail_idx = 0;
   int unsigned fill = 0;

   rsp_type expected_rsp_q [$];

   int errors = 0;
   int n_enq = 0, n_full = 0, n_deq = 0, n_empty = 0;
   int n_search = 0, n_hit = 0, n_nop = 0;

   bit quiet = 1'b0;
   int stall_left = 0;

   // Apply one operation to the shadow ring and return its response
   function automatic rsp_type queue_model_step(req_type item);
      rsp_type     res;
      int unsigned idx;
      int unsigned k;
      res = '0;
      res.status = ST_OK;
      case (item.kind)
         KIND_ENQ: begin
            if (fill >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               cells[tail_idx] = item.value;
               tail_idx = (tail_idx + 1) % DEPTH;
               fill++;
            end
         end
         KIND_DEQ: begin
            if (fill == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.value_out = cells[head_idx];
               head_idx = (head_idx + 1) % DEPTH;
               fill--;
            end
         end
         KIND_SEARCH: begin
            // Oldest match wins: only the first hit sets the position
            res.status = ST_NOTFOUND;
            idx = head_idx;
            for (k = 0; k < fill; k++) begin
               if (res.status == ST_NOTFOUND && cells[idx] == item.value) begin
                  res.status = ST_OK;
                  res.position = CNT_W'(k + 1);
               end
               idx = (idx + 1) % DEPTH;
            end
         end
         default: begin
         end
      endcase
      res.occupancy = CNT_W'(fill);
      res.is_empty = (fill == 0);
      return res;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endfunction

   // Mostly short idle stretches, now and then a long one
   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return $urandom_range(1, 3);
      else if (pick < 95)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   // Full-range words, a small alphabet for duplicates, and the corners
   function automatic word_type random_word();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return $urandom;
      else if (pick < 85)
         return $urandom_range(0, 7);
      case ($urandom_range(0, 3))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return '1;
         default: return '0;
      endcase
   endfunction

   // Mode 0 fills the queue, mode 1 drains it, mode 2 keeps it balanced
   function automatic req_type random_item(int mode);
      req_type item;
      int      roll;
      int      enq_pct;
      int      deq_pct;
      case (mode)
         0: begin enq_pct = 65; deq_pct = 15; end
         1: begin enq_pct = 15; deq_pct = 65; end
         default: begin enq_pct = 40; deq_pct = 37; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < enq_pct)
         item.kind = KIND_ENQ;
      else if (roll < enq_pct + deq_pct)
         item.kind = KIND_DEQ;
      else if (roll < 97)
         item.kind = KIND_SEARCH;
      else
         item.kind = KIND_NOP;
      item.value = random_word();
      // Aim half the searches at a word that is held right now
      if (item.kind == KIND_SEARCH && fill != 0 && $urandom_range(0, 1) == 1)
         item.value = cells[(head_idx + $urandom_range(0, fill - 1)) % DEPTH];
      return item;
   endfunction

   // Present one request and hold it until the transfer
   task automatic send(req_type item, logic known, rsp_type known_rsp);
      req_valid <= 1'b1;
      req_data <= item;
      req_known <= known;
      req_known_rsp <= known_rsp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid for a random gap, or keep streaming
   task automatic pause_sender();
      int gap;
      gap = (quiet || $urandom_range(0, 99) < 45) ? 0 : idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off the sender until every outstanding response is back
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsp_q.size() != 0);
   endtask

   // Receiver back-pressure
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (!quiet && $urandom_range(0, 3) == 0)
            stall_left <= idle_len();
      end
   end

   // Check responses and record expectations on every transfer
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      rsp_type pred;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (expected_rsp_q.size() == 0) begin
               $error("response with nothing outstanding: %p", got);
               errors++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("status", 64'(want.status), 64'(got.status));
               check_field("value_out", 64'($unsigned(want.value_out)),
                           64'($unsigned(got.value_out)));
               check_field("position", 64'(want.position), 64'(got.position));
               check_field("occupancy", 64'(want.occupancy), 64'(got.occupancy));
               check_field("is_empty", 64'(want.is_empty), 64'(got.is_empty));
            end
         end
         if (req_valid && !req_stall) begin
            pred = queue_model_step(req_data);
            case (req_data.kind)
               KIND_ENQ: begin
                  n_enq++;
                  if (pred.status == ST_FULL) n_full++;
               end
               KIND_DEQ: begin
                  n_deq++;
                  if (pred.status == ST_EMPTY) n_empty++;
               end
               KIND_SEARCH: begin
                  n_search++;
                  if (pred.status == ST_OK) n_hit++;
               end
               default: n_nop++;
            endcase
            expected_rsp_q.push_back(req_known ? req_known_rsp : pred);
         end
      end
   end

   // Stimulus
   initial begin
      int      row;
      int      rep;
      int      blk;
      int      n;
      req_type item;
      rsp_type typed;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed plan
      for (row = 0; row < PLAN_ROWS; row++) begin
         for (rep = 0; rep < plan[row].reps; rep++) begin
            item.kind = plan[row].kind;
            item.value = plan[row].value + rep;
            typed = '0;
            typed.status = plan[row].status;
            typed.value_out = plan[row].value_out;
            typed.position = CNT_W'(plan[row].position);
            typed.occupancy = CNT_W'(plan[row].occupancy);
            typed.is_empty = plan[row].is_empty;
            send(item, plan[row].has_rsp, typed);
            pause_sender();
         end
      end
      drain_responses();

      // Random blocks cycling through fill, drain and balanced traffic
      for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         quiet = ($urandom_range(0, 3) == 0);
         for (n = 0; n < ITEMS_PER_BLOCK; n++) begin
            send(random_item(blk % 3), 1'b0, '0);
            pause_sender();
         end
         if ($urandom_range(0, 3) == 0)
            drain_responses();
      end
      quiet = 1'b0;
      drain_responses();
      repeat (4) @(posedge clock);

      $display("covered %0d enqueues (%0d refused on full), %0d dequeues (%0d on empty),",
               n_enq, n_full, n_deq, n_empty);
      $display("%0d searches (%0d hits) and %0d unused codes; %0d mismatches",
               n_search, n_hit, n_nop, errors);
      if (errors == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("testbench NOT OK");
      $finish;
   end

endmodule
